/* rtl/cpp_pkg.sv */
`timescale 1ns / 1ps

package cpp_pkg;

    // Number format and table layout.
    localparam int FRAC_BITS  = 16;
    localparam int DIST_TERMS = 12;
    localparam int EXT_TERMS  = 12;
    localparam int COEF_DEPTH = EXT_TERMS + 4 + DIST_TERMS;
    localparam int COEF_IDX_W = 5;
    localparam int SLOT_OFS_X = 9;
    localparam int SLOT_OFS_Y = 10;
    localparam int SLOT_OFS_Z = 11;
    localparam int SLOT_FX    = EXT_TERMS;
    localparam int SLOT_CX    = EXT_TERMS + 1;
    localparam int SLOT_FY    = EXT_TERMS + 2;
    localparam int SLOT_CY    = EXT_TERMS + 3;
    localparam int SLOT_K     = EXT_TERMS + 4;

    // Datapath widths.
    localparam int VAL_W  = 32;
    localparam int MUL_W  = 2 * VAL_W - FRAC_BITS;
    localparam int ACC_W  = MUL_W + 3;
    localparam int NUM_W  = VAL_W + FRAC_BITS;
    localparam int DIM_W  = 15;
    localparam int PIX_W  = 30;
    localparam int NPROD  = 14;
    localparam int BND_W  = 64;

    // Pipeline depth: the divider latency plus the fixed stages around it.
    localparam int DIV_LAT    = NUM_W + 2;
    localparam int PIPE_DEPTH = 2 * DIV_LAT + 15;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    // Register reset values.
    localparam logic signed [VAL_W-1:0] NEAR_RST   = 32'sd6554;
    localparam logic signed [VAL_W-1:0] FAR_RST    = 32'sd6553600;
    localparam logic [DIM_W-1:0]        WIDTH_RST  = 15'd640;
    localparam logic [DIM_W-1:0]        HEIGHT_RST = 15'd480;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_POINT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_NEAR   = 2'd0,
        CFG_FAR    = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [MUL_W-1:0] t_mul;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [NPROD-1:0][MUL_W-1:0] t_prods;

    localparam t_acc ONE_ACC = {{(ACC_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // Everything one point carries down the pipeline.
    typedef struct packed {
        logic        vld;
        logic        ok;
        logic        zz;
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic        last;
        t_val        x;
        t_val        y;
        t_val        z;
        t_val        r2;
        t_val        r4;
        t_val        a1;
        t_val        a2;
        t_val        a3;
        t_val        cd;
        t_val        den;
        t_val        tx;
        t_val        ty;
        t_val        xd;
        t_val        yd;
        t_acc        ex;
        t_acc        ey;
        t_val        px;
        t_val        py;
        t_prods      m;
    } t_pipe;

    // Fixed-point product, rounded toward minus infinity.
    function automatic t_mul fmul(input t_val a, input t_val b);
        logic signed [2*VAL_W-1:0] p;
        p = a * b;
        return p[2*VAL_W-1:FRAC_BITS];
    endfunction

    function automatic t_acc ext_mul(input t_mul v);
        return {{(ACC_W-MUL_W){v[MUL_W-1]}}, v};
    endfunction

    function automatic t_acc ext_val(input t_val v);
        return {{(ACC_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    // True when the value lies in the signed 32-bit range.
    function automatic logic fits(input t_acc v);
        return (v[ACC_W-1:VAL_W-1] == '0) || (v[ACC_W-1:VAL_W-1] == '1);
    endfunction

endpackage

/* rtl/cpp_div.sv */
`timescale 1ns / 1ps

// Pipelined fixed-point divider: (num * 2^FRAC) / den, truncated toward zero.
// One quotient bit per stage; the output flags a quotient outside 32 bits.
module cpp_div (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  cpp_pkg::t_val        i_num,
    input  cpp_pkg::t_val        i_den,
    output cpp_pkg::t_val        o_quo,
    output logic                 o_ovf
);

    logic [cpp_pkg::VAL_W-1:0] r_den [0:cpp_pkg::NUM_W];
    logic [cpp_pkg::VAL_W-1:0] r_rem [0:cpp_pkg::NUM_W];
    logic [cpp_pkg::NUM_W-1:0] r_num [0:cpp_pkg::NUM_W];
    logic [cpp_pkg::NUM_W-1:0] r_quo [0:cpp_pkg::NUM_W];
    logic                      r_neg [0:cpp_pkg::NUM_W];
    logic [cpp_pkg::VAL_W-1:0] num_mag;
    logic [cpp_pkg::VAL_W-1:0] den_mag;
    logic [cpp_pkg::NUM_W-1:0] q_fin;
    logic                      ovf_fin;

    // Setup: split into magnitudes and a result sign.
    assign num_mag = i_num[cpp_pkg::VAL_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[cpp_pkg::VAL_W-1] ? (~i_den + 1'b1) : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= {num_mag, {cpp_pkg::FRAC_BITS{1'b0}}};
            r_den[0] <= den_mag;
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_neg[0] <= i_num[cpp_pkg::VAL_W-1] ^ i_den[cpp_pkg::VAL_W-1];
        end
    end

    // Restoring division, one bit per stage.
    for (genvar g = 1; g <= cpp_pkg::NUM_W; g++) begin : g_step
        logic [cpp_pkg::VAL_W:0]   trial;
        logic                      ge;
        logic [cpp_pkg::VAL_W:0]   n_rem;

        always_comb begin
            trial = {r_rem[g-1], r_num[g-1][cpp_pkg::NUM_W-1]};
            ge    = trial >= {1'b0, r_den[g-1]};
            n_rem = ge ? (trial - {1'b0, r_den[g-1]}) : trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem[cpp_pkg::VAL_W-1:0];
                r_num[g] <= {r_num[g-1][cpp_pkg::NUM_W-2:0], 1'b0};
                r_quo[g] <= {r_quo[g-1][cpp_pkg::NUM_W-2:0], ge};
                r_den[g] <= r_den[g-1];
                r_neg[g] <= r_neg[g-1];
            end
        end
    end

    // Apply the sign and check the 32-bit range.
    assign q_fin = r_quo[cpp_pkg::NUM_W];
    always_comb begin
        if (r_neg[cpp_pkg::NUM_W]) begin
            ovf_fin = (q_fin[cpp_pkg::NUM_W-1:cpp_pkg::VAL_W] != '0) ||
                      (q_fin[cpp_pkg::VAL_W-1] && (q_fin[cpp_pkg::VAL_W-2:0] != '0));
        end else begin
            ovf_fin = (q_fin[cpp_pkg::NUM_W-1:cpp_pkg::VAL_W-1] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ovf <= ovf_fin;
            o_quo <= r_neg[cpp_pkg::NUM_W] ? (~q_fin[cpp_pkg::VAL_W-1:0] + 1'b1)
                                           : q_fin[cpp_pkg::VAL_W-1:0];
        end
    end

endmodule

/* rtl/camera_point_projection_unit.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// input     | in        | i_in_valid / o_in_ready   | cmd, coef_index/value, point, colors, last
// output    | out       | o_out_valid / i_out_ready | kept, pixel_x/y, colors, cloud_end
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Points enter one per cycle while the output is not stalled; each passes through
// the two 48-step divider pairs (depth and rational term), one quotient bit per stage.
// A coefficient load item waits until every point in flight has left.
// Reset is synchronous: it clears the table and all valid bits and loads register defaults.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module camera_point_projection_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [cpp_pkg::COEF_IDX_W-1:0]    i_coef_index,
    input  logic signed [31:0]                i_coef_value,
    input  logic signed [31:0]                i_point_x,
    input  logic signed [31:0]                i_point_y,
    input  logic signed [31:0]                i_point_z,
    input  logic [31:0]                       i_color_red,
    input  logic [31:0]                       i_color_green,
    input  logic [31:0]                       i_color_blue,
    input  logic                              i_last_point,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_kept,
    output logic [cpp_pkg::PIX_W-1:0]         o_pixel_x,
    output logic [cpp_pkg::PIX_W-1:0]         o_pixel_y,
    output logic [31:0]                       o_out_red,
    output logic [31:0]                       o_out_green,
    output logic [31:0]                       o_out_blue,
    output logic                              o_cloud_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    cpp_pkg::t_val               r_coef [0:cpp_pkg::COEF_DEPTH-1];
    cpp_pkg::t_val               r_near;
    cpp_pkg::t_val               r_far;
    logic [cpp_pkg::DIM_W-1:0]   r_width;
    logic [cpp_pkg::DIM_W-1:0]   r_height;
    logic [cpp_pkg::CNT_W-1:0]   r_cnt;

    cpp_pkg::t_pipe n_s1, r_s1, n_s2, r_s2, n_s3, r_s3, n_s4, r_s4, n_s5, r_s5;
    cpp_pkg::t_pipe n_s6, r_s6, n_s7, r_s7, n_s8, r_s8, n_s9, r_s9, n_s10, r_s10;
    cpp_pkg::t_pipe n_s11, r_s11, n_s12, r_s12, n_s13, r_s13, n_s14, r_s14;
    cpp_pkg::t_pipe n_out, r_out;
    cpp_pkg::t_pipe r_dl1 [0:cpp_pkg::DIV_LAT-1];
    cpp_pkg::t_pipe r_dl2 [0:cpp_pkg::DIV_LAT-1];

    logic           en;
    logic           in_acc;
    logic           pt_acc;
    logic           load_acc;
    logic           out_acc;
    cpp_pkg::t_val  qx, qy, qtx, qty;
    logic           ovf_x, ovf_y, ovf_tx, ovf_ty;
    cpp_pkg::t_acc  s2_sx, s2_sy, s2_sz;
    cpp_pkg::t_val  s2_z;
    cpp_pkg::t_acc  s5_sum, s5_a1, s5_a2, s5_a3;
    cpp_pkg::t_acc  s9_cd, s9_den;
    cpp_pkg::t_acc  s13_xs, s13_ys;
    cpp_pkg::t_acc  o_sx, o_sy;
    cpp_pkg::t_val  o_px, o_py;
    logic [cpp_pkg::BND_W-1:0] w_lim, h_lim;
    logic           o_bad;

    // Handshakes: the pipeline moves whenever the output register can drain.
    assign en          = !r_out.vld || i_out_ready;
    assign o_in_ready  = (cpp_pkg::t_cmd'(i_cmd) == cpp_pkg::CMD_POINT) ? en : (r_cnt == '0);
    assign in_acc      = i_in_valid && o_in_ready;
    assign pt_acc      = in_acc && (cpp_pkg::t_cmd'(i_cmd) == cpp_pkg::CMD_POINT);
    assign load_acc    = in_acc && (cpp_pkg::t_cmd'(i_cmd) == cpp_pkg::CMD_LOAD);
    assign out_acc     = r_out.vld && i_out_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= cpp_pkg::NEAR_RST;
            r_far    <= cpp_pkg::FAR_RST;
            r_width  <= cpp_pkg::WIDTH_RST;
            r_height <= cpp_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (cpp_pkg::t_cfg_idx'(i_cfg_index))
                cpp_pkg::CFG_NEAR:   r_near   <= i_cfg_data;
                cpp_pkg::CFG_FAR:    r_far    <= i_cfg_data;
                cpp_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[cpp_pkg::DIM_W-1:0];
                cpp_pkg::CFG_HEIGHT: r_height <= i_cfg_data[cpp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Coefficient table; a load only lands when no point is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cpp_pkg::COEF_DEPTH; i++) begin
                r_coef[i] <= '0;
            end
        end else if (load_acc && (i_coef_index < cpp_pkg::COEF_IDX_W'(cpp_pkg::COEF_DEPTH))) begin
            r_coef[i_coef_index] <= i_coef_value;
        end
    end

    // Count of points in flight, including the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (pt_acc && !out_acc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (!pt_acc && out_acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Stage 1: extrinsic products.
    always_comb begin
        n_s1       = '0;
        n_s1.vld   = pt_acc;
        n_s1.ok    = 1'b1;
        n_s1.red   = i_color_red;
        n_s1.green = i_color_green;
        n_s1.blue  = i_color_blue;
        n_s1.last  = i_last_point;
        n_s1.m[0]  = cpp_pkg::fmul(r_coef[0], i_point_x);
        n_s1.m[1]  = cpp_pkg::fmul(r_coef[3], i_point_y);
        n_s1.m[2]  = cpp_pkg::fmul(r_coef[6], i_point_z);
        n_s1.m[3]  = cpp_pkg::fmul(r_coef[1], i_point_x);
        n_s1.m[4]  = cpp_pkg::fmul(r_coef[4], i_point_y);
        n_s1.m[5]  = cpp_pkg::fmul(r_coef[7], i_point_z);
        n_s1.m[6]  = cpp_pkg::fmul(r_coef[2], i_point_x);
        n_s1.m[7]  = cpp_pkg::fmul(r_coef[5], i_point_y);
        n_s1.m[8]  = cpp_pkg::fmul(r_coef[8], i_point_z);
    end

    // Stage 2: camera coordinates and depth clip.
    always_comb begin
        s2_sx = cpp_pkg::ext_mul(r_s1.m[0]) + cpp_pkg::ext_mul(r_s1.m[1])
              + cpp_pkg::ext_mul(r_s1.m[2]) + cpp_pkg::ext_val(r_coef[cpp_pkg::SLOT_OFS_X]);
        s2_sy = cpp_pkg::ext_mul(r_s1.m[3]) + cpp_pkg::ext_mul(r_s1.m[4])
              + cpp_pkg::ext_mul(r_s1.m[5]) + cpp_pkg::ext_val(r_coef[cpp_pkg::SLOT_OFS_Y]);
        s2_sz = cpp_pkg::ext_mul(r_s1.m[6]) + cpp_pkg::ext_mul(r_s1.m[7])
              + cpp_pkg::ext_mul(r_s1.m[8]) + cpp_pkg::ext_val(r_coef[cpp_pkg::SLOT_OFS_Z]);
        s2_z  = s2_sz[cpp_pkg::VAL_W-1:0];
        n_s2    = r_s1;
        n_s2.x  = s2_sx[cpp_pkg::VAL_W-1:0];
        n_s2.y  = s2_sy[cpp_pkg::VAL_W-1:0];
        n_s2.z  = s2_z;
        n_s2.zz = (s2_z == '0);
        if (!cpp_pkg::fits(s2_sx) || !cpp_pkg::fits(s2_sy) || !cpp_pkg::fits(s2_sz) ||
            (s2_z <= r_near) || (s2_z >= r_far)) begin
            n_s2.ok = 1'b0;
        end
    end

    // Perspective divide by depth.
    cpp_div u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r_s2.x), .i_den (r_s2.z),
        .o_quo (qx), .o_ovf (ovf_x)
    );
    cpp_div u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r_s2.y), .i_den (r_s2.z),
        .o_quo (qy), .o_ovf (ovf_y)
    );

    // Stage 3: take the quotient unless depth was zero.
    always_comb begin
        n_s3 = r_dl1[cpp_pkg::DIV_LAT-1];
        if (!r_dl1[cpp_pkg::DIV_LAT-1].zz) begin
            n_s3.x = qx;
            n_s3.y = qy;
            if (ovf_x || ovf_y) begin
                n_s3.ok = 1'b0;
            end
        end
    end

    // Stage 4: squares and cross product.
    always_comb begin
        n_s4      = r_s3;
        n_s4.m[0] = cpp_pkg::fmul(r_s3.x, r_s3.x);
        n_s4.m[1] = cpp_pkg::fmul(r_s3.y, r_s3.y);
        n_s4.m[2] = cpp_pkg::fmul(r_s3.x, r_s3.y);
    end

    // Stage 5: r2 and the tangential arguments.
    always_comb begin
        s5_sum = cpp_pkg::ext_mul(r_s4.m[0]) + cpp_pkg::ext_mul(r_s4.m[1]);
        s5_a1  = cpp_pkg::ext_mul(r_s4.m[2]) <<< 1;
        s5_a2  = s5_sum + (cpp_pkg::ext_mul(r_s4.m[0]) <<< 1);
        s5_a3  = s5_sum + (cpp_pkg::ext_mul(r_s4.m[1]) <<< 1);
        n_s5    = r_s4;
        n_s5.r2 = s5_sum[cpp_pkg::VAL_W-1:0];
        n_s5.a1 = s5_a1[cpp_pkg::VAL_W-1:0];
        n_s5.a2 = s5_a2[cpp_pkg::VAL_W-1:0];
        n_s5.a3 = s5_a3[cpp_pkg::VAL_W-1:0];
        if (!cpp_pkg::fits(s5_sum) || !cpp_pkg::fits(s5_a1) ||
            !cpp_pkg::fits(s5_a2) || !cpp_pkg::fits(s5_a3)) begin
            n_s5.ok = 1'b0;
        end
    end

    // Stage 6: r4 product.
    always_comb begin
        n_s6      = r_s5;
        n_s6.m[0] = cpp_pkg::fmul(r_s5.r2, r_s5.r2);
    end

    // Stage 7: r4 check and r6 product.
    always_comb begin
        n_s7      = r_s6;
        n_s7.r4   = r_s6.m[0][cpp_pkg::VAL_W-1:0];
        n_s7.m[1] = cpp_pkg::fmul(r_s6.m[0][cpp_pkg::VAL_W-1:0], r_s6.r2);
        if (!cpp_pkg::fits(cpp_pkg::ext_mul(r_s6.m[0]))) begin
            n_s7.ok = 1'b0;
        end
    end

    // Stage 8: r6 check and all distortion products.
    always_comb begin
        n_s8       = r_s7;
        if (!cpp_pkg::fits(cpp_pkg::ext_mul(r_s7.m[1]))) begin
            n_s8.ok = 1'b0;
        end
        n_s8.m[0]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 0], r_s7.r2);
        n_s8.m[1]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 1], r_s7.r4);
        n_s8.m[2]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 4],
                                   r_s7.m[1][cpp_pkg::VAL_W-1:0]);
        n_s8.m[3]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 5], r_s7.r2);
        n_s8.m[4]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 6], r_s7.r4);
        n_s8.m[5]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 7],
                                   r_s7.m[1][cpp_pkg::VAL_W-1:0]);
        n_s8.m[6]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 2], r_s7.a1);
        n_s8.m[7]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 3], r_s7.a2);
        n_s8.m[8]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 8], r_s7.r2);
        n_s8.m[9]  = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 9], r_s7.r4);
        n_s8.m[10] = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 2], r_s7.a3);
        n_s8.m[11] = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 3], r_s7.a1);
        n_s8.m[12] = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 10], r_s7.r2);
        n_s8.m[13] = cpp_pkg::fmul(r_coef[cpp_pkg::SLOT_K + 11], r_s7.r4);
    end

    // Stage 9: radial and rational polynomials, tangential sums.
    always_comb begin
        s9_cd  = cpp_pkg::ONE_ACC + cpp_pkg::ext_mul(r_s8.m[0])
               + cpp_pkg::ext_mul(r_s8.m[1]) + cpp_pkg::ext_mul(r_s8.m[2]);
        s9_den = cpp_pkg::ONE_ACC + cpp_pkg::ext_mul(r_s8.m[3])
               + cpp_pkg::ext_mul(r_s8.m[4]) + cpp_pkg::ext_mul(r_s8.m[5]);
        n_s9     = r_s8;
        n_s9.cd  = s9_cd[cpp_pkg::VAL_W-1:0];
        n_s9.den = s9_den[cpp_pkg::VAL_W-1:0];
        n_s9.ex  = cpp_pkg::ext_mul(r_s8.m[6]) + cpp_pkg::ext_mul(r_s8.m[7])
                 + cpp_pkg::ext_mul(r_s8.m[8]) + cpp_pkg::ext_mul(r_s8.m[9]);
        n_s9.ey  = cpp_pkg::ext_mul(r_s8.m[10]) + cpp_pkg::ext_mul(r_s8.m[11])
                 + cpp_pkg::ext_mul(r_s8.m[12]) + cpp_pkg::ext_mul(r_s8.m[13]);
        if (!cpp_pkg::fits(s9_cd) || !cpp_pkg::fits(s9_den)) begin
            n_s9.ok = 1'b0;
        end
    end

    // Stage 10: scale by the radial factor.
    always_comb begin
        n_s10      = r_s9;
        n_s10.m[0] = cpp_pkg::fmul(r_s9.x, r_s9.cd);
        n_s10.m[1] = cpp_pkg::fmul(r_s9.y, r_s9.cd);
    end

    // Stage 11: range check; a zero rational denominator drops the point.
    always_comb begin
        n_s11    = r_s10;
        n_s11.tx = r_s10.m[0][cpp_pkg::VAL_W-1:0];
        n_s11.ty = r_s10.m[1][cpp_pkg::VAL_W-1:0];
        if (!cpp_pkg::fits(cpp_pkg::ext_mul(r_s10.m[0])) ||
            !cpp_pkg::fits(cpp_pkg::ext_mul(r_s10.m[1])) || (r_s10.den == '0)) begin
            n_s11.ok = 1'b0;
        end
    end

    // Rational divide.
    cpp_div u_div_tx (
        .i_clk (i_clk), .i_en (en), .i_num (r_s11.tx), .i_den (r_s11.den),
        .o_quo (qtx), .o_ovf (ovf_tx)
    );
    cpp_div u_div_ty (
        .i_clk (i_clk), .i_en (en), .i_num (r_s11.ty), .i_den (r_s11.den),
        .o_quo (qty), .o_ovf (ovf_ty)
    );

    // Stage 12: rational quotient.
    always_comb begin
        n_s12    = r_dl2[cpp_pkg::DIV_LAT-1];
        n_s12.tx = qtx;
        n_s12.ty = qty;
        if (ovf_tx || ovf_ty) begin
            n_s12.ok = 1'b0;
        end
    end

    // Stage 13: distorted coordinates.
    always_comb begin
        s13_xs   = cpp_pkg::ext_val(r_s12.tx) + r_s12.ex;
        s13_ys   = cpp_pkg::ext_val(r_s12.ty) + r_s12.ey;
        n_s13    = r_s12;
        n_s13.xd = s13_xs[cpp_pkg::VAL_W-1:0];
        n_s13.yd = s13_ys[cpp_pkg::VAL_W-1:0];
        if (!cpp_pkg::fits(s13_xs) || !cpp_pkg::fits(s13_ys)) begin
            n_s13.ok = 1'b0;
        end
    end

    // Stage 14: focal scaling.
    always_comb begin
        n_s14      = r_s13;
        n_s14.m[0] = cpp_pkg::fmul(r_s13.xd, r_coef[cpp_pkg::SLOT_FX]);
        n_s14.m[1] = cpp_pkg::fmul(r_s13.yd, r_coef[cpp_pkg::SLOT_FY]);
    end

    // Output stage: principal point and image bounds.
    assign w_lim = {{(cpp_pkg::BND_W-cpp_pkg::DIM_W-cpp_pkg::FRAC_BITS){1'b0}},
                    r_width, {cpp_pkg::FRAC_BITS{1'b0}}};
    assign h_lim = {{(cpp_pkg::BND_W-cpp_pkg::DIM_W-cpp_pkg::FRAC_BITS){1'b0}},
                    r_height, {cpp_pkg::FRAC_BITS{1'b0}}};

    always_comb begin
        o_sx  = cpp_pkg::ext_mul(r_s14.m[0]) + cpp_pkg::ext_val(r_coef[cpp_pkg::SLOT_CX]);
        o_sy  = cpp_pkg::ext_mul(r_s14.m[1]) + cpp_pkg::ext_val(r_coef[cpp_pkg::SLOT_CY]);
        o_px  = o_sx[cpp_pkg::VAL_W-1:0];
        o_py  = o_sy[cpp_pkg::VAL_W-1:0];
        o_bad = !cpp_pkg::fits(o_sx) || !cpp_pkg::fits(o_sy) ||
                o_px[cpp_pkg::VAL_W-1] || o_py[cpp_pkg::VAL_W-1] ||
                o_px[cpp_pkg::PIX_W] || o_py[cpp_pkg::PIX_W] ||
                ({{(cpp_pkg::BND_W-cpp_pkg::PIX_W){1'b0}}, o_px[cpp_pkg::PIX_W-1:0]} > w_lim) ||
                ({{(cpp_pkg::BND_W-cpp_pkg::PIX_W){1'b0}}, o_py[cpp_pkg::PIX_W-1:0]} > h_lim);
        n_out    = r_s14;
        n_out.ok = r_s14.ok && !o_bad;
        n_out.px = n_out.ok ? o_px : '0;
        n_out.py = n_out.ok ? o_py : '0;
    end

    // Pipeline registers; only the valid bits are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld  <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_s3.vld  <= 1'b0;
            r_s4.vld  <= 1'b0;
            r_s5.vld  <= 1'b0;
            r_s6.vld  <= 1'b0;
            r_s7.vld  <= 1'b0;
            r_s8.vld  <= 1'b0;
            r_s9.vld  <= 1'b0;
            r_s10.vld <= 1'b0;
            r_s11.vld <= 1'b0;
            r_s12.vld <= 1'b0;
            r_s13.vld <= 1'b0;
            r_s14.vld <= 1'b0;
            r_out.vld <= 1'b0;
            for (int i = 0; i < cpp_pkg::DIV_LAT; i++) begin
                r_dl1[i].vld <= 1'b0;
                r_dl2[i].vld <= 1'b0;
            end
        end else if (en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_s6  <= n_s6;
            r_s7  <= n_s7;
            r_s8  <= n_s8;
            r_s9  <= n_s9;
            r_s10 <= n_s10;
            r_s11 <= n_s11;
            r_s12 <= n_s12;
            r_s13 <= n_s13;
            r_s14 <= n_s14;
            r_out <= n_out;
            r_dl1[0] <= r_s2;
            r_dl2[0] <= r_s11;
            for (int i = 1; i < cpp_pkg::DIV_LAT; i++) begin
                r_dl1[i] <= r_dl1[i-1];
                r_dl2[i] <= r_dl2[i-1];
            end
        end
    end

    // Result ports.
    assign o_out_valid = r_out.vld;
    assign o_kept      = r_out.ok;
    assign o_pixel_x   = r_out.px[cpp_pkg::PIX_W-1:0];
    assign o_pixel_y   = r_out.py[cpp_pkg::PIX_W-1:0];
    assign o_out_red   = r_out.red;
    assign o_out_green = r_out.green;
    assign o_out_blue  = r_out.blue;
    assign o_cloud_end = r_out.last;

    // A valid result always belongs to a counted point.
    a_cnt_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.vld |-> (r_cnt != '0))
        else $error("result valid with no point in flight");

    // Loads only land on an empty pipeline.
    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |-> (r_cnt == '0))
        else $error("coefficient load while points in flight");

    // The in-flight count never exceeds the number of stages.
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cpp_pkg::CNT_W'(cpp_pkg::PIPE_DEPTH))
        else $error("in-flight count overflow");

    // A dropped point reports a zero pixel.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_kept) |-> ((o_pixel_x == '0) && (o_pixel_y == '0)))
        else $error("dropped point with nonzero pixel");

    // The count rises when a point is accepted and no result leaves.
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pt_acc && !out_acc) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("in-flight count missed a point");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int  HALF       = 6;
    localparam int  SETTLE     = 2 * cpp_pkg::PIPE_DEPTH;
    localparam longint LIMIT   = 3000000;

    typedef struct {
        bit        kept;
        bit [29:0] px;
        bit [29:0] py;
        bit [31:0] red;
        bit [31:0] green;
        bit [31:0] blue;
        bit        last;
    } t_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_cmd = 1'b0;
    logic [4:0]        i_coef_index = '0;
    logic signed [31:0] i_coef_value = '0;
    logic signed [31:0] i_point_x = '0;
    logic signed [31:0] i_point_y = '0;
    logic signed [31:0] i_point_z = '0;
    logic [31:0]       i_color_red = '0;
    logic [31:0]       i_color_green = '0;
    logic [31:0]       i_color_blue = '0;
    logic              i_last_point = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_kept;
    logic [29:0]       o_pixel_x;
    logic [29:0]       o_pixel_y;
    logic [31:0]       o_out_red;
    logic [31:0]       o_out_green;
    logic [31:0]       o_out_blue;
    logic              o_cloud_end;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = '0;
    logic [31:0]       i_cfg_data = '0;

    camera_point_projection_unit dut (.*);

    // Predictor state: coefficient table and clip/bound registers.
    longint cam_coef[cpp_pkg::COEF_DEPTH];
    longint near_q, far_q, width_px, height_px;
    t_pixel pixel_q[$];
    int     errs = 0;
    longint cycles = 0;
    int     snd_idle_pct = 0;
    int     rcv_idle_pct = 0;
    int     hold_req = 0;
    int     hold_left = 0;

    always #HALF i_clk = ~i_clk;

    // Cycle counter with a hard stop.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver ready, with random idling and an optional long hold-off.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Fixed-point helpers of the predictor.
    function automatic longint mulq(longint a, longint b);
        return (a * b) >>> cpp_pkg::FRAC_BITS;
    endfunction

    function automatic longint divq(longint num, longint den);
        return (num * 65536) / den;
    endfunction

    function automatic longint fitq(longint v, inout bit ok);
        if (v < -64'sd2147483648 || v > 64'sd2147483647) begin
            ok = 0;
            return 0;
        end
        return v;
    endfunction

    // Expected pixel for one point under the current table and registers.
    function automatic t_pixel project(longint wx, longint wy, longint wz);
        t_pixel res;
        bit ok;
        longint x, y, z, r2, r4, r6, a1, a2, a3, cd, den, tx, ty, xd, yd, px, py;
        ok = 1;
        x = fitq(mulq(cam_coef[0], wx) + mulq(cam_coef[3], wy) + mulq(cam_coef[6], wz)
                 + cam_coef[9], ok);
        y = fitq(mulq(cam_coef[1], wx) + mulq(cam_coef[4], wy) + mulq(cam_coef[7], wz)
                 + cam_coef[10], ok);
        z = fitq(mulq(cam_coef[2], wx) + mulq(cam_coef[5], wy) + mulq(cam_coef[8], wz)
                 + cam_coef[11], ok);
        if (z <= near_q || z >= far_q) ok = 0;
        // A zero depth leaves x and y unscaled.
        if (z != 0) begin
            x = fitq(divq(x, z), ok);
            y = fitq(divq(y, z), ok);
        end
        r2 = fitq(mulq(x, x) + mulq(y, y), ok);
        r4 = fitq(mulq(r2, r2), ok);
        r6 = fitq(mulq(r4, r2), ok);
        a1 = fitq(2 * mulq(x, y), ok);
        a2 = fitq(r2 + 2 * mulq(x, x), ok);
        a3 = fitq(r2 + 2 * mulq(y, y), ok);
        cd = fitq(65536 + mulq(cam_coef[cpp_pkg::SLOT_K], r2)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+1], r4)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+4], r6), ok);
        den = fitq(65536 + mulq(cam_coef[cpp_pkg::SLOT_K+5], r2)
                   + mulq(cam_coef[cpp_pkg::SLOT_K+6], r4)
                   + mulq(cam_coef[cpp_pkg::SLOT_K+7], r6), ok);
        tx = fitq(mulq(x, cd), ok);
        ty = fitq(mulq(y, cd), ok);
        if (den == 0) begin
            ok = 0;
        end else begin
            tx = fitq(divq(tx, den), ok);
            ty = fitq(divq(ty, den), ok);
        end
        xd = fitq(tx + mulq(cam_coef[cpp_pkg::SLOT_K+2], a1)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+3], a2)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+8], r2)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+9], r4), ok);
        yd = fitq(ty + mulq(cam_coef[cpp_pkg::SLOT_K+2], a3)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+3], a1)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+10], r2)
                  + mulq(cam_coef[cpp_pkg::SLOT_K+11], r4), ok);
        px = fitq(mulq(xd, cam_coef[cpp_pkg::SLOT_FX]) + cam_coef[cpp_pkg::SLOT_CX], ok);
        py = fitq(mulq(yd, cam_coef[cpp_pkg::SLOT_FY]) + cam_coef[cpp_pkg::SLOT_CY], ok);
        if (px < 0 || py < 0 || px > width_px * 65536 || py > height_px * 65536) ok = 0;
        if (px > 64'h3FFF_FFFF || py > 64'h3FFF_FFFF) ok = 0;
        res.kept = ok;
        res.px = ok ? px[29:0] : '0;
        res.py = ok ? py[29:0] : '0;
        return res;
    endfunction

    // One line per mismatch, and a count.
    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errs++;
    endtask

    // Compare every accepted result with the oldest expected pixel.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                want = pixel_q.pop_front();
                if (o_kept !== want.kept) report("kept", o_kept, want.kept);
                if (o_pixel_x !== want.px) report("pixel_x", o_pixel_x, want.px);
                if (o_pixel_y !== want.py) report("pixel_y", o_pixel_y, want.py);
                if (o_out_red !== want.red) report("red", o_out_red, want.red);
                if (o_out_green !== want.green) report("green", o_out_green, want.green);
                if (o_out_blue !== want.blue) report("blue", o_out_blue, want.blue);
                if (o_cloud_end !== want.last) report("cloud_end", o_cloud_end, want.last);
            end
        end
    end

    // Send one item, entered and left at a falling edge.
    task automatic send_item(cpp_pkg::t_cmd cmd, bit [4:0] slot, bit [31:0] value,
                             bit [31:0] wx, bit [31:0] wy, bit [31:0] wz, bit last);
        t_pixel res;
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd = cmd;
        i_coef_index = slot;
        i_coef_value = value;
        i_point_x = wx;
        i_point_y = wy;
        i_point_z = wz;
        i_color_red = $urandom;
        i_color_green = $urandom;
        i_color_blue = $urandom;
        i_last_point = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (cmd == cpp_pkg::CMD_LOAD) begin
            if (slot < cpp_pkg::COEF_DEPTH) cam_coef[slot] = longint'($signed(value));
        end else begin
            res = project(longint'($signed(wx)), longint'($signed(wy)),
                          longint'($signed(wz)));
            res.red = i_color_red;
            res.green = i_color_green;
            res.blue = i_color_blue;
            res.last = last;
            pixel_q.insert(pixel_q.size(), res);
        end
        @(negedge i_clk);
    endtask

    task automatic load_coef(int slot, bit [31:0] value);
        send_item(cpp_pkg::CMD_LOAD, 5'(slot), value, $urandom, $urandom, $urandom,
                  1'($urandom_range(1)));
    endtask

    task automatic send_point(bit [31:0] wx, bit [31:0] wy, bit [31:0] wz, bit last);
        send_item(cpp_pkg::CMD_POINT, 5'($urandom), $urandom, wx, wy, wz, last);
    endtask

    // Wait until every result is back and the pipeline has emptied.
    task automatic drain;
        i_in_valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(cpp_pkg::t_cfg_idx idx, bit [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            cpp_pkg::CFG_NEAR:   near_q = longint'($signed(data));
            cpp_pkg::CFG_FAR:    far_q = longint'($signed(data));
            cpp_pkg::CFG_WIDTH:  width_px = longint'(data[14:0]);
            cpp_pkg::CFG_HEIGHT: height_px = longint'(data[14:0]);
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_regs(bit [31:0] near_v, bit [31:0] far_v, bit [14:0] w, bit [14:0] h);
        write_reg(cpp_pkg::CFG_NEAR, near_v);
        write_reg(cpp_pkg::CFG_FAR, far_v);
        write_reg(cpp_pkg::CFG_WIDTH, 32'(w));
        write_reg(cpp_pkg::CFG_HEIGHT, 32'(h));
    endtask

    // A plausible coefficient for a slot: a near-identity pose, a VGA-like
    // camera and mild distortion.
    function automatic bit [31:0] sane_coef(int slot);
        int jitter;
        jitter = $signed($urandom_range(0, 6000)) - 3000;
        case (slot)
            0, 4, 8:    return 65536 + jitter;
            cpp_pkg::SLOT_OFS_X, cpp_pkg::SLOT_OFS_Y, cpp_pkg::SLOT_OFS_Z:
                        return jitter * 20;
            cpp_pkg::SLOT_FX, cpp_pkg::SLOT_FY: return $urandom_range(200, 400) << 16;
            cpp_pkg::SLOT_CX:    return $urandom_range(250, 390) << 16;
            cpp_pkg::SLOT_CY:    return $urandom_range(180, 300) << 16;
            default:    return jitter;
        endcase
    endfunction

    task automatic load_camera;
        for (int s = 0; s < cpp_pkg::COEF_DEPTH; s++) load_coef(s, sane_coef(s));
    endtask

    // With the table cleared every point lands at depth zero and is clipped.
    task automatic test_empty_table;
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_point(0, 0, 0, 1'b0);
    endtask

    // Extremes of the fields and each special case.
    task automatic test_directed;
        for (int s = 0; s < cpp_pkg::COEF_DEPTH; s++) load_coef(s, 0);
        load_coef(0, 65536);
        load_coef(4, 65536);
        load_coef(8, 65536);
        load_coef(cpp_pkg::SLOT_FX, 300 << 16);
        load_coef(cpp_pkg::SLOT_FY, 300 << 16);
        load_coef(cpp_pkg::SLOT_CX, 320 << 16);
        load_coef(cpp_pkg::SLOT_CY, 240 << 16);
        load_coef(31, 32'h7FFF_FFFF);
        load_coef(28, 32'h8000_0000);
        // Center, near the edges, outside the image, behind the camera.
        send_point(0, 0, 5 << 16, 1'b0);
        send_point(5 << 16, 4 << 16, 5 << 16, 1'b1);
        send_point(-(5 << 16), -(4 << 16), 5 << 16, 1'b0);
        send_point(50 << 16, 0, 5 << 16, 1'b0);
        send_point(0, 0, -(5 << 16), 1'b1);
        send_point(0, 0, 32'h7FFF_FFFF, 1'b0);
        // Overflow in the transform.
        load_coef(3, 32'h7FFF_FFFF);
        send_point(0, 32'h7FFF_FFFF, 5 << 16, 1'b0);
        load_coef(3, 0);
        // Zero rational denominator at a unit radius.
        load_coef(cpp_pkg::SLOT_K + 5, -65536);
        send_point(5 << 16, 0, 5 << 16, 1'b1);
        load_coef(cpp_pkg::SLOT_K + 5, 0);
        drain();
        // Depth zero admitted by the widest clip window.
        set_regs(32'h8000_0000, 32'h7FFF_FFFF, 15'd16384, 15'd16384);
        send_point(65536, 65536, 0, 1'b0);
        // Pixel at 2^30 passes the bound test but not the output range.
        load_coef(cpp_pkg::SLOT_CX, 32'h4000_0000);
        send_point(0, 0, 65536, 1'b0);
        load_coef(cpp_pkg::SLOT_CX, 32'h3FFF_0000);
        send_point(0, 0, 65536, 1'b1);
        drain();
        set_regs(32'h7FFF_FFFF, 32'h8000_0000, 15'd1, 15'd1);
        send_point(0, 0, 65536, 1'b0);
        drain();
    endtask

    // Random clouds: mostly visible points, some reloads, some noise.
    task automatic test_random(int n, int snd, int rcv, int hold);
        int z, roll;
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        hold_req = hold;
        load_camera();
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < 7) begin
                load_coef($urandom_range(cpp_pkg::COEF_DEPTH - 1),
                          sane_coef($urandom_range(cpp_pkg::COEF_DEPTH - 1)));
            end else if (roll < 9) begin
                load_coef($urandom, $urandom);
            end else if (roll < 22) begin
                send_point($urandom, $urandom, $urandom, 1'($urandom_range(1)));
            end else begin
                z = $urandom_range(1 << 16, 40 << 16);
                send_point($signed($urandom_range(0, 2 * z)) - z,
                           $signed($urandom_range(0, 2 * z)) - z,
                           z, ($urandom_range(15) == 0));
            end
        end
        drain();
    endtask

    initial begin
        for (int s = 0; s < cpp_pkg::COEF_DEPTH; s++) cam_coef[s] = 0;
        near_q = longint'(cpp_pkg::NEAR_RST);
        far_q = longint'(cpp_pkg::FAR_RST);
        width_px = longint'(cpp_pkg::WIDTH_RST);
        height_px = longint'(cpp_pkg::HEIGHT_RST);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_directed();
        set_regs(6554, 6553600, 15'd640, 15'd480);
        test_random(610, 18, 79, 0);
        set_regs(0, 32'h7FFF_FFFF, 15'd1024, 15'd768);
        test_random(610, 79, 18, 0);
        set_regs(32'h8000_0000, 40 << 16, 15'd16384, 15'd16384);
        test_random(610, 0, 0, 800);

        if (errs == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
